[hdl/tcpq_pkg.sv]
package tcpq_pkg;

   localparam int CODE_BITS         = 16;
   localparam int COUNT_BITS        = 7;
   localparam int CLASS_DEPTH_DEF   = 64;
   localparam int RESULT_LIMIT      = 64;

   typedef enum logic {
      CMD_ARRIVE = 1'b0,
      CMD_SERVE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_SERVED   = 2'd0,
      STATUS_ACCEPTED = 2'd1,
      STATUS_DROPPED  = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                command;
      logic [CODE_BITS-1:0]   customer_code;
      logic                   preferential;
      logic [COUNT_BITS-1:0]  serve_count;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [CODE_BITS-1:0]   served_code;
      logic                   served_preferential;
      logic                   last_of_run;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      cmd_type                op;
      logic [CODE_BITS-1:0]   code;
      logic                   pref;
      logic [COUNT_BITS-1:0]  limit;
   } op_type;

   // metadata of a result whose code is still being read from a store
   typedef struct packed {
      status_type             status;
      logic                   pref;
      logic                   last;
   } meta_type;

endpackage

[hdl/tcpq_front.sv]
module tcpq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcpq_pkg::req_type req_data,
   output logic              op_valid,
   output tcpq_pkg::op_type  op_data,
   input  logic              op_pop
);

   tcpq_pkg::op_type op_new;
   tcpq_pkg::op_type q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;

   // serve counts beyond the result limit saturate here
   always_comb begin
      op_new.op   = req_data.command;
      op_new.code = req_data.customer_code;
      op_new.pref = req_data.preferential;
      if (req_data.serve_count > tcpq_pkg::COUNT_BITS'(tcpq_pkg::RESULT_LIMIT)) begin
         op_new.limit = tcpq_pkg::COUNT_BITS'(tcpq_pkg::RESULT_LIMIT);
      end else begin
         op_new.limit = req_data.serve_count;
      end
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign op_valid  = (cnt_ff != 2'd0);
   assign op_data   = q0_ff;

   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_ff;
      if (op_pop && push) begin
         if (cnt_ff == 2'd2) begin
            q0_in = q1_ff;
            q1_in = op_new;
         end else begin
            q0_in = op_new;
         end
      end else if (op_pop) begin
         q0_in  = q1_ff;
         cnt_in = cnt_ff - 2'd1;
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            q0_in = op_new;
         end else begin
            q1_in = op_new;
         end
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

endmodule

[hdl/tcpq_back.sv]
module tcpq_back #(
   parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   input  tcpq_pkg::op_type  op_data,
   output logic              op_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcpq_pkg::rsp_type rsp_data
);

   localparam int AW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
   localparam int CW = $clog2(CLASS_DEPTH + 1);
   localparam int CB = tcpq_pkg::CODE_BITS;
   localparam int NB = tcpq_pkg::COUNT_BITS;

   logic [CB-1:0] pref_mem [CLASS_DEPTH];
   logic [CB-1:0] ord_mem  [CLASS_DEPTH];
   logic [CB-1:0] pref_rd_ff, ord_rd_ff;

   logic [AW-1:0] pref_head_ff, pref_head_in, pref_tail_ff, pref_tail_in;
   logic [AW-1:0] ord_head_ff, ord_head_in, ord_tail_ff, ord_tail_in;
   logic [CW-1:0] pref_count_ff, pref_count_in, ord_count_ff, ord_count_in;
   logic [NB-1:0] served_ff, served_in;

   logic               s1_valid_ff;
   tcpq_pkg::meta_type s1_meta_ff, meta_in;
   logic               rsp_valid_ff;
   tcpq_pkg::rsp_type  rsp_data_ff, rsp_in;

   logic adv, fire, is_arrive, class_full, pref_ne, ord_ne, take, last_take;
   logic wr_pref, wr_ord, rd_pref, rd_ord;

   // whole back pipe moves when the output register can take a beat
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign fire      = adv && op_valid;
   assign is_arrive = (op_data.op == tcpq_pkg::CMD_ARRIVE);
   assign pref_ne   = (pref_count_ff != '0);
   assign ord_ne    = (ord_count_ff != '0);
   assign class_full = op_data.pref ? (pref_count_ff == CW'(CLASS_DEPTH))
                                    : (ord_count_ff == CW'(CLASS_DEPTH));
   assign take      = (served_ff < op_data.limit) && (pref_ne || ord_ne);
   assign last_take = (served_ff + NB'(1) == op_data.limit) ||
                      (pref_ne ? (pref_count_ff == CW'(1) && !ord_ne)
                               : (ord_count_ff == CW'(1)));

   assign wr_pref = fire && is_arrive && !class_full && op_data.pref;
   assign wr_ord  = fire && is_arrive && !class_full && !op_data.pref;
   assign rd_pref = fire && !is_arrive && take && pref_ne;
   assign rd_ord  = fire && !is_arrive && take && !pref_ne;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      if (p == AW'(CLASS_DEPTH - 1)) begin
         return '0;
      end
      return p + AW'(1);
   endfunction

   always_comb begin
      meta_in.pref = 1'b0;
      meta_in.last = 1'b1;
      op_pop       = 1'b0;
      served_in    = served_ff;
      if (is_arrive) begin
         meta_in.status = class_full ? tcpq_pkg::STATUS_DROPPED
                                     : tcpq_pkg::STATUS_ACCEPTED;
         op_pop = fire;
      end else if (take) begin
         meta_in.status = tcpq_pkg::STATUS_SERVED;
         meta_in.pref   = pref_ne;
         meta_in.last   = last_take;
         if (fire) begin
            op_pop    = last_take;
            served_in = last_take ? '0 : served_ff + NB'(1);
         end
      end else begin
         meta_in.status = tcpq_pkg::STATUS_EMPTY;
         op_pop = fire;
      end
   end

   always_comb begin
      pref_head_in  = rd_pref ? wrap_inc(pref_head_ff) : pref_head_ff;
      ord_head_in   = rd_ord  ? wrap_inc(ord_head_ff)  : ord_head_ff;
      pref_tail_in  = wr_pref ? wrap_inc(pref_tail_ff) : pref_tail_ff;
      ord_tail_in   = wr_ord  ? wrap_inc(ord_tail_ff)  : ord_tail_ff;
      pref_count_in = pref_count_ff;
      ord_count_in  = ord_count_ff;
      if (wr_pref) pref_count_in = pref_count_ff + CW'(1);
      if (rd_pref) pref_count_in = pref_count_ff - CW'(1);
      if (wr_ord)  ord_count_in  = ord_count_ff + CW'(1);
      if (rd_ord)  ord_count_in  = ord_count_ff - CW'(1);
   end

   always_comb begin
      rsp_in.status              = s1_meta_ff.status;
      rsp_in.last_of_run         = s1_meta_ff.last;
      rsp_in.served_preferential = 1'b0;
      rsp_in.served_code         = '0;
      if (s1_meta_ff.status == tcpq_pkg::STATUS_SERVED) begin
         rsp_in.served_preferential = s1_meta_ff.pref;
         rsp_in.served_code         = s1_meta_ff.pref ? pref_rd_ff : ord_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_pref) pref_mem[pref_tail_ff] <= op_data.code;
      if (rd_pref) pref_rd_ff <= pref_mem[pref_head_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_ord) ord_mem[ord_tail_ff] <= op_data.code;
      if (rd_ord) ord_rd_ff <= ord_mem[ord_head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pref_head_ff  <= '0;
         pref_tail_ff  <= '0;
         pref_count_ff <= '0;
         ord_head_ff   <= '0;
         ord_tail_ff   <= '0;
         ord_count_ff  <= '0;
         served_ff     <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pref_head_ff  <= pref_head_in;
         pref_tail_ff  <= pref_tail_in;
         pref_count_ff <= pref_count_in;
         ord_head_ff   <= ord_head_in;
         ord_tail_ff   <= ord_tail_in;
         ord_count_ff  <= ord_count_in;
         served_ff     <= served_in;
         if (adv) begin
            s1_valid_ff  <= fire;
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_meta_ff  <= meta_in;
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/two_class_priority_queue.sv]
// Two-class strict priority queue.
// req channel: one beat per command. An arrival (command 0) puts customer_code
// into the preferential or ordinary store; a serve (command 1) removes up to
// serve_count entries (saturating at 64), preferential ones first, FIFO order
// within each class.
// rsp channel: an arrival gives one beat, accepted or dropped (class store
// full). A serve gives one beat per served entry with its code and class, or a
// single "nothing to serve" beat; last_of_run marks the final beat of a command.
// Throughput: arrivals are taken one per cycle and a serve gives one result
// beat per cycle while rsp_ready is high; a serve holds the back end for its
// whole run, and a two-entry command queue keeps req_ready high until it fills
// behind that serve. Path: command queue, store read register, output register.
// Reset empties both classes and all pipeline stages; store contents are not
// cleared, no sweep is needed. While a result beat waits with rsp_ready low,
// the whole back end holds, the output beat stays put, and the command queue
// fills before req_ready drops.
module two_class_priority_queue #(
   parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tcpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tcpq_pkg::rsp_type rsp_data
);

   logic             op_valid;
   logic             op_pop;
   tcpq_pkg::op_type op_data;

   tcpq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .op_valid  (op_valid),
      .op_data   (op_data),
      .op_pop    (op_pop)
   );

   tcpq_back #(
      .CLASS_DEPTH (CLASS_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_data   (op_data),
      .op_pop    (op_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/tcpq_checker.sv]
module tcpq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tcpq_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tcpq_pkg::rsp_type rsp_data
);

   // a stalled command beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req beat changed while stalled");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // non-served results end their run and carry no code or class
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != tcpq_pkg::STATUS_SERVED |->
         rsp_data.last_of_run && rsp_data.served_code == '0 &&
         !rsp_data.served_preferential)
      else $error("status beat malformed");

   // no result beat before a command accepted after reset can reach the output
   a_no_early_rsp: assert property (@(posedge clock)
      !reset && ($past(reset, 1) || $past(reset, 2)) |-> !rsp_valid)
      else $error("rsp beat too soon after reset");

endmodule

bind two_class_priority_queue tcpq_checker u_tcpq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[bench/testbench.sv]
module testbench;

   localparam int DEPTH     = tcpq_pkg::CLASS_DEPTH_DEF;
   localparam int WD_LIMIT  = 5000;
   localparam int HOLD_LEN  = 120;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   tcpq_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tcpq_pkg::rsp_type rsp_data;

   two_class_priority_queue #(.CLASS_DEPTH(DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // commands waiting to be driven, customers in line, beats still owed
   tcpq_pkg::req_type               cmd_backlog[$];
   logic [tcpq_pkg::CODE_BITS-1:0]  pref_line[$];
   logic [tcpq_pkg::CODE_BITS-1:0]  plain_line[$];
   tcpq_pkg::rsp_type               outcomes_due[$];

   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_token = 0;
   int hold_seen  = 0;
   int hold_left  = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   // admit or serve against the local copy of both lines
   function automatic void queue_outcome(tcpq_pkg::req_type r);
      tcpq_pkg::rsp_type o;
      int      take;
      int      served;
      served = 0;
      o = '0;
      if (r.command == tcpq_pkg::CMD_ARRIVE) begin
         o.last_of_run = 1'b1;
         if (r.preferential) begin
            if (pref_line.size() >= DEPTH) begin
               o.status = tcpq_pkg::STATUS_DROPPED;
            end else begin
               pref_line.push_back(r.customer_code);
               o.status = tcpq_pkg::STATUS_ACCEPTED;
            end
         end else begin
            if (plain_line.size() >= DEPTH) begin
               o.status = tcpq_pkg::STATUS_DROPPED;
            end else begin
               plain_line.push_back(r.customer_code);
               o.status = tcpq_pkg::STATUS_ACCEPTED;
            end
         end
         outcomes_due.push_back(o);
      end else begin
         take = (r.serve_count > tcpq_pkg::RESULT_LIMIT) ? tcpq_pkg::RESULT_LIMIT
                                                          : int'(r.serve_count);
         while (served < take && (pref_line.size() != 0 || plain_line.size() != 0)) begin
            o = '0;
            o.status = tcpq_pkg::STATUS_SERVED;
            if (pref_line.size() != 0) begin
               o.served_code = pref_line.pop_front();
               o.served_preferential = 1'b1;
            end else begin
               o.served_code = plain_line.pop_front();
            end
            outcomes_due.push_back(o);
            served++;
         end
         if (served == 0) begin
            o = '0;
            o.status = tcpq_pkg::STATUS_EMPTY;
            o.last_of_run = 1'b1;
            outcomes_due.push_back(o);
         end else begin
            o = outcomes_due.pop_back();
            o.last_of_run = 1'b1;
            outcomes_due.push_back(o);
         end
      end
   endfunction

   function automatic tcpq_pkg::req_type make_arrival(
      logic [tcpq_pkg::CODE_BITS-1:0] code, logic pref);
      tcpq_pkg::req_type r;
      r.command       = tcpq_pkg::CMD_ARRIVE;
      r.customer_code = code;
      r.preferential  = pref;
      r.serve_count   = tcpq_pkg::COUNT_BITS'($urandom);
      return r;
   endfunction

   function automatic tcpq_pkg::req_type make_serve(logic [tcpq_pkg::COUNT_BITS-1:0] cnt);
      tcpq_pkg::req_type r;
      r.command       = tcpq_pkg::CMD_SERVE;
      r.customer_code = tcpq_pkg::CODE_BITS'($urandom);
      r.preferential  = 1'($urandom);
      r.serve_count   = cnt;
      return r;
   endfunction

   function automatic tcpq_pkg::req_type random_command(int arrive_pct);
      int pick;
      logic [tcpq_pkg::COUNT_BITS-1:0] cnt;
      pick = $urandom_range(99);
      if (pick < 10)      cnt = '0;
      else if (pick < 75) cnt = tcpq_pkg::COUNT_BITS'($urandom_range(6, 1));
      else if (pick < 88) cnt = tcpq_pkg::COUNT_BITS'($urandom_range(63, 7));
      else                cnt = tcpq_pkg::COUNT_BITS'($urandom_range(127, 64));
      if ($urandom_range(99) < arrive_pct)
         return make_arrival(tcpq_pkg::CODE_BITS'($urandom), 1'($urandom));
      return make_serve(cnt);
   endfunction

   // overfill one class so arrivals get dropped, touch the other, then empty out
   task automatic push_fill(logic pref);
      for (int i = 0; i < DEPTH + 3; i++) begin
         cmd_backlog.push_back(make_arrival(tcpq_pkg::CODE_BITS'($urandom), pref));
         if (i % 20 == 7)
            cmd_backlog.push_back(make_arrival(tcpq_pkg::CODE_BITS'($urandom), !pref));
      end
      cmd_backlog.push_back(make_serve(7'd64));
      cmd_backlog.push_back(make_serve(7'd127));
      cmd_backlog.push_back(make_serve(7'd1));
   endtask

   task automatic wait_drained;
      while (cmd_backlog.size() != 0 || req_valid || outcomes_due.size() != 0)
         @(negedge clock);
   endtask

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            queue_outcome(req_data);
         if (!req_valid || req_ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_data  <= cmd_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_LEN;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response side
   always @(posedge clock) begin
      tcpq_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcomes_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: status %0d code %h pref %b last %b",
                           rsp_data.status, rsp_data.served_code,
                           rsp_data.served_preferential, rsp_data.last_of_run);
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_data.status !== want.status
                   || rsp_data.served_code !== want.served_code
                   || rsp_data.served_preferential !== want.served_preferential
                   || rsp_data.last_of_run !== want.last_of_run) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected status %0d code %h pref %b last %b,",
                               " got status %0d code %h pref %b last %b"},
                              want.status, want.served_code, want.served_preferential,
                              want.last_of_run, rsp_data.status, rsp_data.served_code,
                              rsp_data.served_preferential, rsp_data.last_of_run);
               end
            end
         end
         if (hold_token != hold_seen || hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WD_LIMIT)
         @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int idle_by_phase[4];
      int stall_by_phase[4];
      idle_by_phase  = '{0, 82, 0, 31};
      stall_by_phase = '{0, 0, 82, 31};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty serves, code extremes in both classes, zero and saturating counts
      cmd_backlog.push_back(make_serve(7'd0));
      cmd_backlog.push_back(make_serve(7'd5));
      cmd_backlog.push_back(make_arrival(16'h0000, 1'b0));
      cmd_backlog.push_back(make_arrival(16'hFFFF, 1'b0));
      cmd_backlog.push_back(make_arrival(16'hFFFF, 1'b1));
      cmd_backlog.push_back(make_arrival(16'h0000, 1'b1));
      cmd_backlog.push_back(make_serve(7'd0));
      cmd_backlog.push_back(make_serve(7'd1));
      cmd_backlog.push_back(make_arrival(16'h1234, 1'b0));
      cmd_backlog.push_back(make_arrival(16'hA5A5, 1'b1));
      cmd_backlog.push_back(make_serve(7'd127));
      cmd_backlog.push_back(make_serve(7'd64));
      cmd_backlog.push_back(make_arrival(16'h5A5A, 1'b1));
      cmd_backlog.push_back(make_arrival(16'h8001, 1'b0));
      cmd_backlog.push_back(make_arrival(16'h7FFE, 1'b1));
      cmd_backlog.push_back(make_serve(7'd2));
      cmd_backlog.push_back(make_serve(7'd65));
      cmd_backlog.push_back(make_serve(7'd1));
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_by_phase[p];
         stall_pct = stall_by_phase[p];
         // long receiver hold-off while the sender keeps offering beats
         if (p == 0)
            hold_token++;
         for (int i = 0; i < 50; i++)
            cmd_backlog.push_back(random_command(60));
         if (p == 0 || p == 2)
            push_fill(p == 0);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
hdl/tcpq_pkg.sv
hdl/tcpq_front.sv
hdl/tcpq_back.sv
hdl/two_class_priority_queue.sv
hdl/tcpq_checker.sv
bench/testbench.sv
